/* rtl/core/hds_pkg.sv */
`timescale 1ns / 1ps

package hds_pkg;

    // Default scaling; the top level overrides these through its parameters
    localparam int DUTY_MAX_DEF       = 10000;
    localparam int CMD_FULL_SCALE_DEF = 1000;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int CMD_W   = 10;
    localparam int DIRECT_W = 16;
    localparam int LEG_W   = 14;
    localparam int STEP_W  = 14;
    localparam int CFG_DW  = 14;
    localparam int CFG_IW  = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PEDAL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DIRECT = 2'd2;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_SLEW_UP    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SLEW_DOWN  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LEFT_INV   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_RIGHT_INV  = 3'd4;

    // Register reset values
    localparam logic [STEP_W-1:0] SLEW_UP_RST   = 14'd500;
    localparam logic [STEP_W-1:0] SLEW_DOWN_RST = 14'd200;
    localparam logic [CMD_W-1:0]  THRESHOLD_RST = 10'd20;

    typedef struct packed {
        logic [STEP_W-1:0] slew_up;
        logic [STEP_W-1:0] slew_down;
        logic [CMD_W-1:0]  threshold;
        logic              left_inv;
        logic              right_inv;
    } cfg_t;

endpackage

/* rtl/core/hbridge_duty_slew_drive.sv */
`timescale 1ns / 1ps

// Dual H-bridge duty drive with slew limiting. One transfer in gives one
// transfer out: the four leg duties (forward drives leg 1, reverse leg 2).
// A pedal tick scales throttle_cmd by pwm_limit, clamps it to full scale,
// maps it onto 0..DUTY_MAX and slews each motor's kept duty toward it; a
// change of direction snaps that motor's duty to zero first. A direct
// command (func 2, direct_enable set) drives the given duties, clamped,
// and leaves the slew state alone. Emergency stop (func 1), the spare
// func 3, or a direct command with direct_enable low zeroes every leg
// and both kept duties. Sequencing: a pedal tick runs the one shared
// multiplier twice, each time through a three-pass divide-by-full-scale
// (product, reciprocal estimate, back-multiply and correction). Stop and
// direct commands skip the multiplier. in_stall is high while an item
// is in work and while a finished result cannot leave because out_stall
// holds the output register.
// Registers may only be written while the block is idle.
module hbridge_duty_slew_drive
#(
    parameter int DUTY_MAX       = hds_pkg::DUTY_MAX_DEF,
    parameter int CMD_FULL_SCALE = hds_pkg::CMD_FULL_SCALE_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration
    input  logic                           cfg_we,
    input  logic [hds_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [hds_pkg::CFG_DW-1:0]     cfg_data,

    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hds_pkg::FUNC_W-1:0]     func,
    input  logic [hds_pkg::CMD_W-1:0]      throttle_cmd,
    input  logic                           throttle_enable_request,
    input  logic                           drive_enable,
    input  logic                           throttle_valid,
    input  logic [hds_pkg::CMD_W-1:0]      pwm_limit,
    input  logic                           requested_direction,
    input  logic [hds_pkg::DIRECT_W-1:0]   direct_duty_left,
    input  logic [hds_pkg::DIRECT_W-1:0]   direct_duty_right,
    input  logic                           direct_dir_left,
    input  logic                           direct_dir_right,
    input  logic                           direct_enable,

    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hds_pkg::LEG_W-1:0]      left_leg1_duty,
    output logic [hds_pkg::LEG_W-1:0]      left_leg2_duty,
    output logic [hds_pkg::LEG_W-1:0]      right_leg1_duty,
    output logic [hds_pkg::LEG_W-1:0]      right_leg2_duty
);

    localparam int DW  = $clog2(DUTY_MAX + 1);
    localparam int CW  = $clog2(CMD_FULL_SCALE + 1);
    localparam int XW  = (CW > hds_pkg::CMD_W) ? CW : hds_pkg::CMD_W;
    localparam int YW  = (DW > hds_pkg::CMD_W) ? DW : hds_pkg::CMD_W;
    localparam int PW  = XW + YW;
    localparam int LW  = hds_pkg::LEG_W;
    localparam int VW  = hds_pkg::DIRECT_W;

    // sequencer
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_E_START = 3'd1;
    localparam logic [2:0] ST_E_WAIT  = 3'd2;
    localparam logic [2:0] ST_T_START = 3'd3;
    localparam logic [2:0] ST_T_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    hds_pkg::cfg_t cfg;

    logic [2:0] state_reg, state_next;

    // captured item
    logic [hds_pkg::FUNC_W-1:0] func_reg;
    logic [hds_pkg::CMD_W-1:0]  cmd_reg, limit_reg;
    logic                       gate_en_reg, gate_vld_reg, dir_reg;
    logic [VW-1:0]              dduty_l_reg, dduty_r_reg;
    logic                       ddir_l_reg, ddir_r_reg, den_reg;

    // working values
    logic [CW-1:0] eff_reg;
    logic [DW-1:0] tgt_reg;

    // slew state
    logic [DW-1:0] cur_l_reg, cur_r_reg;
    logic          prev_l_reg, prev_r_reg;

    // output register
    logic          out_valid_reg;
    logic [LW-1:0] l1_reg, l2_reg, r1_reg, r2_reg;

    logic          accept, out_free, out_load;
    logic          md_start, md_done;
    logic [XW-1:0] md_x;
    logic [YW-1:0] md_y;
    logic [PW-1:0] md_res;

    logic          dir_l, dir_r, go;
    logic [DW-1:0] target, base_l, base_r, slew_l, slew_r;
    logic          is_pedal, is_direct;
    logic [VW-1:0] drv_l, drv_r, dclamp_l, dclamp_r;
    logic          drv_dir_l, drv_dir_r;

    hds_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // operands: throttle x limit first, then effective command x duty range
    assign md_start = (state_reg == ST_E_START) || (state_reg == ST_T_START);
    assign md_x     = (state_reg == ST_T_START) ? XW'(eff_reg) : XW'(cmd_reg);
    assign md_y     = (state_reg == ST_T_START) ? YW'(DUTY_MAX) : YW'(limit_reg);

    hds_muldiv
    #(
        .XW  (XW),
        .YW  (YW),
        .CFS (CMD_FULL_SCALE)
    )
    u_muldiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .x      (md_x),
        .y      (md_y),
        .done   (md_done),
        .result (md_res)
    );

    // pedal path: polarity, gating, snap to zero on reversal, slew
    assign dir_l  = dir_reg ^ cfg.left_inv;
    assign dir_r  = dir_reg ^ cfg.right_inv;
    assign go     = gate_en_reg && gate_vld_reg && (cmd_reg >= cfg.threshold);
    assign target = go ? tgt_reg : '0;
    assign base_l = (dir_l != prev_l_reg) ? '0 : cur_l_reg;
    assign base_r = (dir_r != prev_r_reg) ? '0 : cur_r_reg;

    hds_slew #(.DW (DW)) u_slew_l
    (
        .cur       (base_l),
        .target    (target),
        .step_up   (cfg.slew_up),
        .step_down (cfg.slew_down),
        .duty      (slew_l)
    );

    hds_slew #(.DW (DW)) u_slew_r
    (
        .cur       (base_r),
        .target    (target),
        .step_up   (cfg.slew_up),
        .step_down (cfg.slew_down),
        .duty      (slew_r)
    );

    // direct path clamps to the duty range
    assign dclamp_l = (dduty_l_reg > VW'(DUTY_MAX)) ? VW'(DUTY_MAX) : dduty_l_reg;
    assign dclamp_r = (dduty_r_reg > VW'(DUTY_MAX)) ? VW'(DUTY_MAX) : dduty_r_reg;

    assign is_pedal  = (func_reg == hds_pkg::FUNC_PEDAL);
    assign is_direct = (func_reg == hds_pkg::FUNC_DIRECT) && den_reg;

    always_comb
    begin
        drv_l     = '0;
        drv_r     = '0;
        drv_dir_l = 1'b0;
        drv_dir_r = 1'b0;
        if (is_pedal)
        begin
            drv_l     = VW'(slew_l);
            drv_r     = VW'(slew_r);
            drv_dir_l = dir_l;
            drv_dir_r = dir_r;
        end
        else if (is_direct)
        begin
            drv_l     = dclamp_l;
            drv_r     = dclamp_r;
            drv_dir_l = ddir_l_reg;
            drv_dir_r = ddir_r_reg;
        end
    end

    // handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (func == hds_pkg::FUNC_PEDAL) ? ST_E_START : ST_OUT;
                end
            end
            ST_E_START: state_next = ST_E_WAIT;
            ST_E_WAIT:
            begin
                if (md_done)
                begin
                    state_next = ST_T_START;
                end
            end
            ST_T_START: state_next = ST_T_WAIT;
            ST_T_WAIT:
            begin
                if (md_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_l_reg     <= '0;
            cur_r_reg     <= '0;
            prev_l_reg    <= 1'b0;
            prev_r_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                if (is_pedal)
                begin
                    cur_l_reg  <= slew_l;
                    cur_r_reg  <= slew_r;
                    prev_l_reg <= dir_l;
                    prev_r_reg <= dir_r;
                end
                else if (!is_direct)
                begin
                    // stop keeps the directions
                    cur_l_reg <= '0;
                    cur_r_reg <= '0;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            cmd_reg      <= throttle_cmd;
            limit_reg    <= pwm_limit;
            gate_en_reg  <= throttle_enable_request && drive_enable;
            gate_vld_reg <= throttle_valid;
            dir_reg      <= requested_direction;
            dduty_l_reg  <= direct_duty_left;
            dduty_r_reg  <= direct_duty_right;
            ddir_l_reg   <= direct_dir_left;
            ddir_r_reg   <= direct_dir_right;
            den_reg      <= direct_enable;
        end
        if ((state_reg == ST_E_WAIT) && md_done)
        begin
            eff_reg <= (md_res > PW'(CMD_FULL_SCALE)) ? CW'(CMD_FULL_SCALE) : CW'(md_res);
        end
        if ((state_reg == ST_T_WAIT) && md_done)
        begin
            tgt_reg <= DW'(md_res);
        end
        if (out_load)
        begin
            l1_reg <= drv_dir_l ? '0 : drv_l[LW-1:0];
            l2_reg <= drv_dir_l ? drv_l[LW-1:0] : '0;
            r1_reg <= drv_dir_r ? '0 : drv_r[LW-1:0];
            r2_reg <= drv_dir_r ? drv_r[LW-1:0] : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign left_leg1_duty  = l1_reg;
    assign left_leg2_duty  = l2_reg;
    assign right_leg1_duty = r1_reg;
    assign right_leg2_duty = r2_reg;

`ifndef ASSERT_OFF
    // a bridge never drives both legs at once
    a_left_legs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_leg1_duty == '0 || left_leg2_duty == '0))
        else $error("left legs both driven");

    a_right_legs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_leg1_duty == '0 || right_leg2_duty == '0))
        else $error("right legs both driven");

    // kept duties stay in range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DW'(cur_l_reg) <= DW'(DUTY_MAX)) && (DW'(cur_r_reg) <= DW'(DUTY_MAX)))
        else $error("kept duty above maximum");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken while busy");

    // divider results only arrive while the sequencer waits for them
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_E_WAIT || state_reg == ST_T_WAIT))
        else $error("unexpected divider result");
`endif

endmodule

/* rtl/core/hds_cfg_regs.sv */
`timescale 1ns / 1ps

module hds_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hds_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [hds_pkg::CFG_DW-1:0]    cfg_data,
    output hds_pkg::cfg_t                 cfg
);

    hds_pkg::cfg_t cfg_reg;

    // Unknown indexes fall through and are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_up   <= hds_pkg::SLEW_UP_RST;
            cfg_reg.slew_down <= hds_pkg::SLEW_DOWN_RST;
            cfg_reg.threshold <= hds_pkg::THRESHOLD_RST;
            cfg_reg.left_inv  <= 1'b0;
            cfg_reg.right_inv <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hds_pkg::REG_SLEW_UP:   cfg_reg.slew_up   <= cfg_data;
                hds_pkg::REG_SLEW_DOWN: cfg_reg.slew_down <= cfg_data;
                hds_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_data[hds_pkg::CMD_W-1:0];
                hds_pkg::REG_LEFT_INV:  cfg_reg.left_inv  <= cfg_data[0];
                hds_pkg::REG_RIGHT_INV: cfg_reg.right_inv <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/hds_muldiv.sv */
`timescale 1ns / 1ps

// floor(x * y / CFS) with one shared multiplier: product, reciprocal
// estimate, back-multiply, then a single +1 correction.
module hds_muldiv
#(
    parameter int XW  = 12,
    parameter int YW  = 16,
    parameter int CFS = 1000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [XW-1:0]     x,
    input  logic [YW-1:0]     y,
    output logic              done,
    output logic [XW+YW-1:0]  result
);

    localparam int PW = XW + YW;
    localparam int MW = 2 * PW;
    // estimate error stays below one for any product under 2**PW
    localparam logic [63:0] RECIP_FULL = (64'd1 << PW) / CFS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_REC  = 2'd1;
    localparam logic [1:0] PH_COR  = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [MW-1:0] m_reg, m_next;
    logic [PW-1:0] p_reg, q_reg, res_reg;
    logic          done_reg;
    logic [PW-1:0] mul_a, mul_b;
    logic [PW-1:0] rem;

    always_comb
    begin
        mul_a      = PW'(x);
        mul_b      = PW'(y);
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_REC;
                end
            end
            PH_REC:
            begin
                mul_a      = m_reg[PW-1:0];
                mul_b      = RECIP_FULL[PW-1:0];
                phase_next = PH_COR;
            end
            PH_COR:
            begin
                mul_a      = m_reg[MW-1:PW];
                mul_b      = PW'(CFS);
                phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign m_next = MW'(mul_a) * MW'(mul_b);
    assign rem    = p_reg - m_reg[PW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        if (phase_reg == PH_REC)
        begin
            p_reg <= m_reg[PW-1:0];
        end
        if (phase_reg == PH_COR)
        begin
            q_reg <= m_reg[MW-1:PW];
        end
        if (phase_reg == PH_FIX)
        begin
            res_reg <= (rem >= PW'(CFS)) ? q_reg + PW'(1) : q_reg;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/hds_slew.sv */
`timescale 1ns / 1ps

// One slew step toward target; a zero step holds the duty in that direction.
module hds_slew
#(
    parameter int DW = 14
)
(
    input  logic [DW-1:0]               cur,
    input  logic [DW-1:0]               target,
    input  logic [hds_pkg::STEP_W-1:0]  step_up,
    input  logic [hds_pkg::STEP_W-1:0]  step_down,
    output logic [DW-1:0]               duty
);

    localparam int AW = ((DW > hds_pkg::STEP_W) ? DW : hds_pkg::STEP_W) + 1;

    logic [AW-1:0] cur_w, tgt_w, up_w, down_w;

    assign cur_w  = AW'(cur);
    assign tgt_w  = AW'(target);
    assign up_w   = AW'(step_up);
    assign down_w = AW'(step_down);

    always_comb
    begin
        duty = cur;
        if (cur_w < tgt_w)
        begin
            duty = (tgt_w - cur_w > up_w) ? DW'(cur_w + up_w) : target;
        end
        else if (cur_w > tgt_w)
        begin
            duty = (cur_w - tgt_w > down_w) ? DW'(cur_w - down_w) : target;
        end
    end

endmodule

/* dv/hds_leg_checker.sv */
`timescale 1ns / 1ps

// Watches the register port and both channels, keeps its own copy of the
// drive state and predicts the four leg duties of every transfer in.
module hds_leg_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hds_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [hds_pkg::CFG_DW-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [hds_pkg::FUNC_W-1:0]     func,
    input  logic [hds_pkg::CMD_W-1:0]      throttle_cmd,
    input  logic                           throttle_enable_request,
    input  logic                           drive_enable,
    input  logic                           throttle_valid,
    input  logic [hds_pkg::CMD_W-1:0]      pwm_limit,
    input  logic                           requested_direction,
    input  logic [hds_pkg::DIRECT_W-1:0]   direct_duty_left,
    input  logic [hds_pkg::DIRECT_W-1:0]   direct_duty_right,
    input  logic                           direct_dir_left,
    input  logic                           direct_dir_right,
    input  logic                           direct_enable,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [hds_pkg::LEG_W-1:0]      left_leg1_duty,
    input  logic [hds_pkg::LEG_W-1:0]      left_leg2_duty,
    input  logic [hds_pkg::LEG_W-1:0]      right_leg1_duty,
    input  logic [hds_pkg::LEG_W-1:0]      right_leg2_duty,
    output int                             mismatches,
    output int                             in_flight,
    output int                             results_checked
);

    localparam int DUTY_FULL = hds_pkg::DUTY_MAX_DEF;
    localparam int CMD_FULL  = hds_pkg::CMD_FULL_SCALE_DEF;
    localparam int LW        = hds_pkg::LEG_W;

    typedef struct {
        logic [hds_pkg::FUNC_W-1:0]   func;
        logic [hds_pkg::CMD_W-1:0]    cmd;
        logic                         ter;
        logic                         de;
        logic                         tv;
        logic [hds_pkg::CMD_W-1:0]    limit;
        logic                         dir;
        logic [hds_pkg::DIRECT_W-1:0] duty_l;
        logic [hds_pkg::DIRECT_W-1:0] duty_r;
        logic                         dir_l;
        logic                         dir_r;
        logic                         den;
    } drive_cmd_t;

    typedef struct {
        logic [LW-1:0] l1;
        logic [LW-1:0] l2;
        logic [LW-1:0] r1;
        logic [LW-1:0] r2;
    } leg_set_t;

    // register copy
    logic [hds_pkg::STEP_W-1:0] up_step   = hds_pkg::SLEW_UP_RST;
    logic [hds_pkg::STEP_W-1:0] down_step = hds_pkg::SLEW_DOWN_RST;
    logic [hds_pkg::CMD_W-1:0]  threshold = hds_pkg::THRESHOLD_RST;
    logic                       left_inv  = 1'b0;
    logic                       right_inv = 1'b1;

    // kept duties and last directions
    int   left_duty  = 0;
    int   right_duty = 0;
    logic left_dir   = 1'b0;
    logic right_dir  = 1'b0;

    leg_set_t legs_due[$];
    int       err_count = 0;
    int       result_no = 0;

    task automatic report_mismatch(string what, logic [LW-1:0] got,
                                   logic [LW-1:0] want);
        $display("[%0t] result %0d: %s is %0d, predicted %0d",
                 $time, result_no, what, got, want);
        err_count++;
    endtask

    function automatic int slew_toward(int cur, int tgt);
        if (cur < tgt)
            return (tgt - cur > int'(up_step)) ? cur + int'(up_step) : tgt;
        if (cur > tgt)
            return (cur - tgt > int'(down_step)) ? cur - int'(down_step) : tgt;
        return cur;
    endfunction

    // forward drives leg 1, reverse leg 2
    function automatic void bridge_legs(input int duty, input logic dir,
                                        output logic [LW-1:0] fwd,
                                        output logic [LW-1:0] rev);
        int d;
        d   = (duty > DUTY_FULL) ? DUTY_FULL : duty;
        fwd = dir ? '0 : d[LW-1:0];
        rev = dir ? d[LW-1:0] : '0;
    endfunction

    task automatic predict_legs(input drive_cmd_t c, output leg_set_t r);
        int   target;
        int   eff;
        logic dl;
        logic dr;
        r = '{default: '0};
        if (c.func == hds_pkg::FUNC_PEDAL)
        begin
            dl     = c.dir ^ left_inv;
            dr     = c.dir ^ right_inv;
            target = 0;
            if (c.ter && c.de && c.tv && c.cmd >= threshold)
            begin
                eff = int'(c.cmd) * int'(c.limit) / CMD_FULL;
                if (eff > CMD_FULL)
                    eff = CMD_FULL;
                target = eff * DUTY_FULL / CMD_FULL;
            end
            if (dl != left_dir)
                left_duty = 0;
            if (dr != right_dir)
                right_duty = 0;
            left_dir   = dl;
            right_dir  = dr;
            left_duty  = slew_toward(left_duty, target);
            right_duty = slew_toward(right_duty, target);
            bridge_legs(left_duty, dl, r.l1, r.l2);
            bridge_legs(right_duty, dr, r.r1, r.r2);
        end
        else if (c.func == hds_pkg::FUNC_DIRECT && c.den)
        begin
            bridge_legs(int'(c.duty_l), c.dir_l, r.l1, r.l2);
            bridge_legs(int'(c.duty_r), c.dir_r, r.r1, r.r2);
        end
        else
        begin
            // stop, spare code or disabled direct: directions are kept
            left_duty  = 0;
            right_duty = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_cmd_t c;
        leg_set_t   r;
        leg_set_t   w;
        if (!rst_n)
        begin
            up_step         = hds_pkg::SLEW_UP_RST;
            down_step       = hds_pkg::SLEW_DOWN_RST;
            threshold       = hds_pkg::THRESHOLD_RST;
            left_inv        = 1'b0;
            right_inv       = 1'b1;
            left_duty       = 0;
            right_duty      = 0;
            left_dir        = 1'b0;
            right_dir       = 1'b0;
            legs_due.delete();
            in_flight       <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hds_pkg::REG_SLEW_UP:   up_step   = cfg_data[hds_pkg::STEP_W-1:0];
                    hds_pkg::REG_SLEW_DOWN: down_step = cfg_data[hds_pkg::STEP_W-1:0];
                    hds_pkg::REG_THRESHOLD: threshold = cfg_data[hds_pkg::CMD_W-1:0];
                    hds_pkg::REG_LEFT_INV:  left_inv  = cfg_data[0];
                    hds_pkg::REG_RIGHT_INV: right_inv = cfg_data[0];
                    default: ;
                endcase
            end

            // results first, so a transfer in at this edge is not matched
            if (out_valid && !out_stall)
            begin
                result_no++;
                if (legs_due.size() == 0)
                    report_mismatch("result with none pending", left_leg1_duty, '0);
                else
                begin
                    w = legs_due.pop_front();
                    if (left_leg1_duty !== w.l1)
                        report_mismatch("left_leg1_duty", left_leg1_duty, w.l1);
                    if (left_leg2_duty !== w.l2)
                        report_mismatch("left_leg2_duty", left_leg2_duty, w.l2);
                    if (right_leg1_duty !== w.r1)
                        report_mismatch("right_leg1_duty", right_leg1_duty, w.r1);
                    if (right_leg2_duty !== w.r2)
                        report_mismatch("right_leg2_duty", right_leg2_duty, w.r2);
                end
            end

            if (in_valid && !in_stall)
            begin
                c.func   = func;
                c.cmd    = throttle_cmd;
                c.ter    = throttle_enable_request;
                c.de     = drive_enable;
                c.tv     = throttle_valid;
                c.limit  = pwm_limit;
                c.dir    = requested_direction;
                c.duty_l = direct_duty_left;
                c.duty_r = direct_duty_right;
                c.dir_l  = direct_dir_left;
                c.dir_r  = direct_dir_right;
                c.den    = direct_enable;
                predict_legs(c, r);
                legs_due.push_back(r);
            end

            in_flight <= legs_due.size();
        end
        mismatches      <= err_count;
        results_checked <= result_no;
    end

endmodule

/* dv/hbridge_duty_slew_drive_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict. Prediction and comparison live in hds_leg_checker.
module hbridge_duty_slew_drive_tb;

    typedef logic [hds_pkg::FUNC_W-1:0]   func_t;
    typedef logic [hds_pkg::CMD_W-1:0]    cmd_t;
    typedef logic [hds_pkg::DIRECT_W-1:0] dduty_t;
    typedef logic [hds_pkg::LEG_W-1:0]    leg_t;
    typedef logic [hds_pkg::CFG_IW-1:0]   cfg_idx_t;
    typedef logic [hds_pkg::CFG_DW-1:0]   cfg_val_t;

    // spare operation code, decoded by the block as an emergency stop
    localparam func_t FUNC_SPARE = 2'd3;

    localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES  = 16;    // covers a pedal tick, plus margin
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 140;

    typedef struct {
        func_t  func;
        cmd_t   cmd;
        logic   ter;
        logic   de;
        logic   tv;
        cmd_t   limit;
        logic   dir;
        dduty_t duty_l;
        dduty_t duty_r;
        logic   dir_l;
        logic   dir_r;
        logic   den;
    } drive_cmd_t;

    // every input known from time zero
    logic     clk                     = 1'b0;
    logic     rst_n                   = 1'b0;
    logic     cfg_we                  = 1'b0;
    cfg_idx_t cfg_index               = '0;
    cfg_val_t cfg_data                = '0;
    logic     in_valid                = 1'b0;
    func_t    func                    = '0;
    cmd_t     throttle_cmd            = '0;
    logic     throttle_enable_request = 1'b0;
    logic     drive_enable            = 1'b0;
    logic     throttle_valid          = 1'b0;
    cmd_t     pwm_limit               = '0;
    logic     requested_direction     = 1'b0;
    dduty_t   direct_duty_left        = '0;
    dduty_t   direct_duty_right       = '0;
    logic     direct_dir_left         = 1'b0;
    logic     direct_dir_right        = 1'b0;
    logic     direct_enable           = 1'b0;
    logic     out_stall               = 1'b0;

    logic     in_stall;
    logic     out_valid;
    leg_t     left_leg1_duty;
    leg_t     left_leg2_duty;
    leg_t     right_leg1_duty;
    leg_t     right_leg2_duty;

    int mismatches;
    int in_flight;
    int results_checked;

    // sender pacing, receiver stall pattern, watchdog
    int burst_left   = 0;
    int stall_mode   = 0;
    int stall_seg    = 0;
    int stall_tick   = 0;
    int quiet_cycles = 0;

    // run tallies for the summary
    int n_pedal    = 0;
    int n_stop     = 0;
    int n_direct   = 0;
    int n_settings = 0;

    // direction the random pedal traffic is currently cruising in
    logic cruise_dir = 1'b0;
    cmd_t thresh_now = hds_pkg::THRESHOLD_RST;

    always #5 clk = ~clk;

    hbridge_duty_slew_drive DUT (.*);

    hds_leg_checker legs_chk (.*);

    // Receiver: segments of random length, each with its own stall style:
    // none, sparse random, a fixed 6-in-17 rhythm (walks across every
    // phase of the pedal tick), or heavy stalling.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_seg == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_seg  <= $urandom_range(40, 300);
        end
        else
            stall_seg <= stall_seg - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ((stall_tick % 17) < 6);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random content in every field; callers then set what matters.
    function automatic drive_cmd_t noise_cmd(func_t f);
        drive_cmd_t c;
        c.func   = f;
        c.cmd    = cmd_t'($urandom_range(0, 1023));
        c.ter    = ($urandom_range(0, 1) != 0);
        c.de     = ($urandom_range(0, 1) != 0);
        c.tv     = ($urandom_range(0, 1) != 0);
        c.limit  = cmd_t'($urandom_range(0, 1023));
        c.dir    = ($urandom_range(0, 1) != 0);
        c.duty_l = dduty_t'($urandom_range(0, 65535));
        c.duty_r = dduty_t'($urandom_range(0, 65535));
        c.dir_l  = ($urandom_range(0, 1) != 0);
        c.dir_r  = ($urandom_range(0, 1) != 0);
        c.den    = ($urandom_range(0, 1) != 0);
        return c;
    endfunction

    // flags are {throttle_enable_request, drive_enable, throttle_valid}
    function automatic drive_cmd_t pedal(int cmd, int lim, logic [2:0] flags,
                                         logic dir);
        drive_cmd_t c;
        c                = noise_cmd(hds_pkg::FUNC_PEDAL);
        c.cmd            = cmd_t'(cmd);
        c.limit          = cmd_t'(lim);
        {c.ter, c.de, c.tv} = flags;
        c.dir            = dir;
        return c;
    endfunction

    function automatic drive_cmd_t direct(logic den, int dl, int dr,
                                          logic dirl, logic dirr);
        drive_cmd_t c;
        c        = noise_cmd(hds_pkg::FUNC_DIRECT);
        c.den    = den;
        c.duty_l = dduty_t'(dl);
        c.duty_r = dduty_t'(dr);
        c.dir_l  = dirl;
        c.dir_r  = dirr;
        return c;
    endfunction

    // Mostly well-formed pedal runs in a steady direction with the command
    // above threshold; the rest stops, spare codes, direct commands and
    // unconstrained noise.
    function automatic drive_cmd_t rand_cmd();
        drive_cmd_t c;
        int         k;
        k = $urandom_range(0, 99);
        if (k < 70)
        begin
            c = noise_cmd(hds_pkg::FUNC_PEDAL);
            if ($urandom_range(0, 9) != 0)
                {c.ter, c.de, c.tv} = 3'b111;
            if ($urandom_range(0, 9) == 0)
                cruise_dir = ~cruise_dir;
            c.dir = cruise_dir;
            if ($urandom_range(0, 4) != 0)
                c.cmd = cmd_t'($urandom_range(int'(thresh_now), 1000));
            if ($urandom_range(0, 9) < 7)
                c.limit = cmd_t'($urandom_range(500, 1000));
        end
        else if (k < 78)
            c = noise_cmd(hds_pkg::FUNC_STOP);
        else if (k < 82)
            c = noise_cmd(FUNC_SPARE);
        else
        begin
            c     = noise_cmd(hds_pkg::FUNC_DIRECT);
            c.den = ($urandom_range(0, 19) > 2);
            if ($urandom_range(0, 9) < 7)
                c.duty_l = dduty_t'($urandom_range(0, 10000));
            if ($urandom_range(0, 9) < 7)
                c.duty_r = dduty_t'($urandom_range(0, 10000));
        end
        return c;
    endfunction

    // Sender works in bursts; a gap only drops valid between transfers.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 19) == 0)
                gap = 30;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    task automatic send_cmd(drive_cmd_t c);
        pace();
        func                    <= c.func;
        throttle_cmd            <= c.cmd;
        throttle_enable_request <= c.ter;
        drive_enable            <= c.de;
        throttle_valid          <= c.tv;
        pwm_limit               <= c.limit;
        requested_direction     <= c.dir;
        direct_duty_left        <= c.duty_l;
        direct_duty_right       <= c.duty_r;
        direct_dir_left         <= c.dir_l;
        direct_dir_right        <= c.dir_r;
        direct_enable           <= c.den;
        in_valid                <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c.func == hds_pkg::FUNC_PEDAL)
            n_pedal++;
        else if (c.func == hds_pkg::FUNC_DIRECT && c.den)
            n_direct++;
        else
            n_stop++;
    endtask

    // Drop valid, wait for every predicted result, then let the block settle.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_val_t d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // All five registers, then a write to an unmapped index that must be
    // ignored. Only called with the block idle.
    task automatic load_settings(int su, int sd, int th, logic li, logic ri);
        cfg_idx_t spare_idx;
        spare_idx = cfg_idx_t'(int'(hds_pkg::REG_RIGHT_INV) + 1 + $urandom_range(0, 2));
        write_reg(hds_pkg::REG_SLEW_UP, cfg_val_t'(su));
        write_reg(hds_pkg::REG_SLEW_DOWN, cfg_val_t'(sd));
        write_reg(hds_pkg::REG_THRESHOLD, cfg_val_t'(th));
        write_reg(hds_pkg::REG_LEFT_INV, cfg_val_t'(li));
        write_reg(hds_pkg::REG_RIGHT_INV, cfg_val_t'(ri));
        write_reg(spare_idx, cfg_val_t'($urandom_range(0, 16383)));
        cfg_we     <= 1'b0;
        thresh_now = cmd_t'(th);
        n_settings++;
    endtask

    initial
    begin
        int su;
        int sd;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values (up 500, down 200, thr 20).
        // ramp up, then a command whose scaled value overshoots full scale
        repeat (3) send_cmd(pedal(1000, 1000, 3'b111, 1'b0));
        send_cmd(pedal(1023, 1023, 3'b111, 1'b0));
        // reversal snaps both duties to zero before slewing again
        send_cmd(pedal(1000, 1000, 3'b111, 1'b1));
        send_cmd(pedal(1000, 500, 3'b111, 1'b1));
        // just under and exactly at threshold, then all zero
        send_cmd(pedal(19, 1000, 3'b111, 1'b1));
        send_cmd(pedal(20, 1000, 3'b111, 1'b1));
        send_cmd(pedal(0, 0, 3'b111, 1'b1));
        // each enable missing in turn
        send_cmd(pedal(1000, 1000, 3'b110, 1'b1));
        send_cmd(pedal(1000, 1000, 3'b101, 1'b1));
        send_cmd(pedal(1000, 1000, 3'b011, 1'b1));
        send_cmd(noise_cmd(hds_pkg::FUNC_STOP));
        repeat (2) send_cmd(pedal(700, 1000, 3'b111, 1'b0));
        send_cmd(noise_cmd(FUNC_SPARE));
        send_cmd(pedal(700, 1000, 3'b111, 1'b0));
        // direct duties above the maximum are clamped
        send_cmd(direct(1'b1, 65535, 0, 1'b0, 1'b1));
        send_cmd(direct(1'b1, 10000, 10001, 1'b1, 1'b0));
        send_cmd(direct(1'b1, 16383, 9999, 1'b1, 1'b1));
        // slew state must be as the last pedal tick left it
        send_cmd(pedal(700, 1000, 3'b111, 1'b0));
        // direct with enable low behaves as a stop
        send_cmd(direct(1'b0, 5000, 5000, 1'b0, 1'b0));
        send_cmd(pedal(700, 1000, 3'b111, 1'b0));

        // Random part, one register setting per phase. The fixed settings
        // cover the extremes, a zero up step and a zero down step.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p)
                0: load_settings(1, 1, 0, 1'b1, 1'b0);
                1: load_settings(10000, 10000, 1000, 1'b1, 1'b1);
                2: load_settings(0, 300, 5, 1'b0, 1'b1);
                3: load_settings(400, 0, 5, 1'b1, 1'b0);
                4: load_settings(16383, 1, 0, 1'b0, 1'b0);
                default:
                begin
                    su = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 600)
                                                     : $urandom_range(1, 10000);
                    sd = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 600)
                                                     : $urandom_range(1, 10000);
                    load_settings(su, sd, $urandom_range(0, 1000),
                                  ($urandom_range(0, 1) != 0),
                                  ($urandom_range(0, 1) != 0));
                end
            endcase
            repeat (PHASE_ITEMS) send_cmd(rand_cmd());
        end

        settle();

        $display("Sent %0d transfers: %0d pedal ticks, %0d stops, %0d direct",
                 n_pedal + n_stop + n_direct, n_pedal, n_stop, n_direct);
        $display("%0d register settings after reset, %0d results checked",
                 n_settings, results_checked);
        if (mismatches == 0 && in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hds_pkg.sv
rtl/core/hds_cfg_regs.sv
rtl/core/hds_muldiv.sv
rtl/core/hds_slew.sv
rtl/core/hbridge_duty_slew_drive.sv
dv/hds_leg_checker.sv
dv/hbridge_duty_slew_drive_tb.sv
